// File: rtl/core/tgr_pkg.sv
// Shared constants, types and helpers for the Tiger-192 hash engine.
`timescale 1ns / 1ps

package tgr_pkg;

    // Pass count limits and the counter width that holds a pass count
    localparam int MAX_PASSES = 8;
    localparam int MIN_PASSES = 3;
    localparam int PASS_W     = $clog2(MAX_PASSES + 1);

    localparam int WORD_W = 64;
    localparam int VB_W   = 4;

    // APB register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_NUM_PASSES = 1'b0;   // register index, from paddr[2]
    localparam logic [VB_W-1:0] NUM_PASSES_RST = 4'd3;

    // Chaining values after reset and at the start of every message
    localparam logic [63:0] IV_A = 64'h0123456789ABCDEF;
    localparam logic [63:0] IV_B = 64'hFEDCBA9876543210;
    localparam logic [63:0] IV_C = 64'hF096A5B4C3B2E187;

    // Key schedule constants
    localparam logic [63:0] KS_FIRST = 64'hA5A5A5A5A5A5A5A5;
    localparam logic [63:0] KS_LAST  = 64'h0123456789ABCDEF;

    // Seed block for S-box generation, word k holds seed bytes 8k..8k+7
    localparam logic [7:0][63:0] SEED_BLOCK = {
        64'h6D6168694220696C,
        64'h4520646E61206E6F,
        64'h737265646E412073,
        64'h736F52207962202C,
        64'h6E6F6974636E7546,
        64'h2068736148207765,
        64'h4E20747361462041,
        64'h202D207265676954
    };

    // S-box read addresses: four tables, two ports each
    typedef struct packed {
        logic [3:0][1:0][7:0] addr;
    } t_sbox_rd;

    typedef logic [3:0][1:0][63:0] t_sbox_rdata;

    // S-box write: one address and word, an enable per table
    typedef struct packed {
        logic [3:0]  en;
        logic [7:0]  addr;
        logic [63:0] data;
    } t_sbox_wr;

    // Commands to the round engine
    typedef struct packed {
        logic              start;
        logic              seed;
        logic [PASS_W-1:0] passes;
        logic              shift;
        logic [63:0]       word;
        logic              init;
    } t_cmp_cmd;

    // Status of the round engine
    typedef struct packed {
        logic             done;
        logic [2:0][63:0] chain;
    } t_cmp_sts;

    // Clamp the programmed pass count into the supported range
    function automatic logic [PASS_W-1:0] eff_passes(input logic [VB_W-1:0] n);
        if (int'(n) < MIN_PASSES) begin
            return PASS_W'(MIN_PASSES);
        end else if (int'(n) > MAX_PASSES) begin
            return PASS_W'(MAX_PASSES);
        end
        return PASS_W'(n);
    endfunction

endpackage

// File: rtl/core/tgr_if.sv
// Valid/ready channel interfaces for message words and digests.
`timescale 1ns / 1ps

interface tgr_in_if;
    logic                       valid;
    logic                       ready;
    logic [tgr_pkg::WORD_W-1:0] data_word;
    logic [tgr_pkg::VB_W-1:0]   valid_bytes;
    logic                       last_word;

    modport source (output valid, data_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface tgr_out_if;
    logic                       valid;
    logic                       ready;
    logic [tgr_pkg::WORD_W-1:0] digest_a;
    logic [tgr_pkg::WORD_W-1:0] digest_b;
    logic [tgr_pkg::WORD_W-1:0] digest_c;

    modport source (output valid, digest_a, digest_b, digest_c, input ready);
    modport sink   (input valid, digest_a, digest_b, digest_c, output ready);
endinterface

// File: rtl/core/tgr_sbox.sv
// Four 256x64 S-box memories, two registered read ports and one write port each.
`timescale 1ns / 1ps

module tgr_sbox (
    input  logic                 i_clk,
    input  tgr_pkg::t_sbox_rd    i_rd,
    input  tgr_pkg::t_sbox_wr    i_wr,
    output tgr_pkg::t_sbox_rdata o_rdata
);
    import tgr_pkg::*;

    for (genvar t = 0; t < 4; t++) begin : g_tab
        logic [63:0] r_mem [256];
        logic [63:0] r_rd0;
        logic [63:0] r_rd1;

        // write then registered reads
        always_ff @(posedge i_clk) begin
            if (i_wr.en[t]) begin
                r_mem[i_wr.addr] <= i_wr.data;
            end
            r_rd0 <= r_mem[i_rd.addr[t][0]];
            r_rd1 <= r_mem[i_rd.addr[t][1]];
        end

        assign o_rdata[t][0] = r_rd0;
        assign o_rdata[t][1] = r_rd1;
    end

endmodule

// File: rtl/core/tgr_round.sv
// Round engine: key ring, working registers, key schedule and chaining value.
`timescale 1ns / 1ps

module tgr_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tgr_pkg::t_cmp_cmd    i_cmd,
    input  tgr_pkg::t_sbox_rdata i_rdata,
    output tgr_pkg::t_sbox_rd    o_rd,
    output tgr_pkg::t_cmp_sts    o_sts
);
    import tgr_pkg::*;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_RD   = 3'd1;
    localparam logic [2:0] C_ADD  = 3'd2;
    localparam logic [2:0] C_MUL  = 3'd3;
    localparam logic [2:0] C_MIX  = 3'd4;
    localparam logic [2:0] C_FF   = 3'd5;

    logic [2:0]        r_state;
    logic [PASS_W-1:0] r_pass;
    logic [PASS_W-1:0] r_passes;
    logic [2:0]        r_round;
    logic [3:0]        r_step;
    logic              r_done;
    logic [2:0][63:0]  r_chain;
    logic [7:0][63:0]  r_key;
    logic [63:0]       r_wa, r_wb, r_wc;
    logic [63:0]       r_v, r_anew, r_bsum;

    logic [63:0] v, xa, xb, bsh, bmul, mix_cur, mix_prev, mix_pp, n_mix;

    // round input and S-box addresses
    assign v = r_wc ^ r_key[0];
    always_comb begin
        o_rd.addr[0][0] = v[7:0];
        o_rd.addr[0][1] = v[63:56];
        o_rd.addr[1][0] = v[23:16];
        o_rd.addr[1][1] = v[47:40];
        o_rd.addr[2][0] = v[39:32];
        o_rd.addr[2][1] = v[31:24];
        o_rd.addr[3][0] = v[55:48];
        o_rd.addr[3][1] = v[15:8];
    end

    assign xa = i_rdata[0][0] ^ i_rdata[1][0] ^ i_rdata[2][0] ^ i_rdata[3][0];
    assign xb = i_rdata[0][1] ^ i_rdata[1][1] ^ i_rdata[2][1] ^ i_rdata[3][1];

    // multiply by 5, 7 or 9 with one shift and one add or subtract
    assign bsh  = (r_pass == '0) ? (r_bsum << 2) : (r_bsum << 3);
    assign bmul = (r_pass == PASS_W'(1)) ? (bsh - r_bsum) : (bsh + r_bsum);

    // one key schedule step on the head of the ring
    assign mix_cur  = r_key[0];
    assign mix_prev = r_key[7];
    assign mix_pp   = r_key[6];
    always_comb begin
        case (r_step) inside
            4'd0:                      n_mix = mix_cur - (mix_prev ^ KS_FIRST);
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:
                                       n_mix = mix_cur ^ mix_prev;
            4'd2, 4'd5, 4'd8, 4'd11, 4'd14:
                                       n_mix = mix_cur + mix_prev;
            4'd3, 4'd9:                n_mix = mix_cur - (mix_prev ^ ((~mix_pp) << 19));
            4'd6, 4'd12:               n_mix = mix_cur - (mix_prev ^ ((~mix_pp) >> 23));
            default:                   n_mix = mix_cur - (mix_prev ^ KS_LAST);
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_chain <= {IV_C, IV_B, IV_A};
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_cmd.init) begin
                        r_chain <= {IV_C, IV_B, IV_A};
                    end
                    if (i_cmd.start) begin
                        r_state <= C_RD;
                    end
                end
                C_RD:  r_state <= C_ADD;
                C_ADD: r_state <= C_MUL;
                C_MUL: begin
                    if (r_round == 3'd7) begin
                        r_state <= (r_pass == PASS_W'(r_passes - 1'b1)) ? C_FF : C_MIX;
                    end else begin
                        r_state <= C_RD;
                    end
                end
                C_MIX: begin
                    if (r_step == 4'd15) begin
                        r_state <= C_RD;
                    end
                end
                C_FF: begin
                    r_chain[0] <= r_chain[0] ^ r_wa;
                    r_chain[1] <= r_wb - r_chain[1];
                    r_chain[2] <= r_chain[2] + r_wc;
                    r_done     <= 1'b1;
                    r_state    <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_cmd.shift) begin
                    r_key <= {i_cmd.word, r_key[7:1]};
                end
                if (i_cmd.start) begin
                    if (i_cmd.seed) begin
                        r_key <= SEED_BLOCK;
                    end
                    r_wa     <= r_chain[0];
                    r_wb     <= r_chain[1];
                    r_wc     <= r_chain[2];
                    r_passes <= i_cmd.passes;
                    r_pass   <= '0;
                    r_round  <= '0;
                end
            end
            C_RD: begin
                r_v   <= v;
                r_key <= {r_key[0], r_key[7:1]};
            end
            C_ADD: begin
                r_anew <= r_wa - xa;
                r_bsum <= r_wb + xb;
            end
            C_MUL: begin
                // roles rotate each round; eight rounds leave the pass-end order
                r_wa    <= bmul;
                r_wb    <= r_v;
                r_wc    <= r_anew;
                r_round <= r_round + 3'd1;
                r_step  <= '0;
                if (r_round == 3'd7) begin
                    r_pass <= r_pass + 1'b1;
                end
            end
            C_MIX: begin
                r_key  <= {n_mix, r_key[7:1]};
                r_step <= r_step + 4'd1;
            end
            default: ;
        endcase
    end

    assign o_sts.done  = r_done;
    assign o_sts.chain = r_chain;

endmodule

// File: rtl/core/tgr_sgen.sv
// S-box builder: fills the tables, then permutes them with the seed compressions.
`timescale 1ns / 1ps

module tgr_sgen (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tgr_pkg::t_cmp_sts    i_sts,
    input  tgr_pkg::t_sbox_rdata i_rdata,
    output tgr_pkg::t_cmp_cmd    o_cmd,
    output tgr_pkg::t_sbox_rd    o_rd,
    output logic                 o_rd_own,
    output tgr_pkg::t_sbox_wr    o_wr,
    output logic                 o_done
);
    import tgr_pkg::*;

    localparam logic [2:0] G_FILL = 3'd0;
    localparam logic [2:0] G_STEP = 3'd1;
    localparam logic [2:0] G_WAIT = 3'd2;
    localparam logic [2:0] G_RD   = 3'd3;
    localparam logic [2:0] G_CAP  = 3'd4;
    localparam logic [2:0] G_W1   = 3'd5;
    localparam logic [2:0] G_W2   = 3'd6;
    localparam logic [2:0] G_DONE = 3'd7;

    logic [2:0]  r_state;
    logic [7:0]  r_i, r_k;
    logic [2:0]  r_cnt, r_col;
    logic [1:0]  r_sb, r_abc;
    logic [63:0] r_di, r_dk;

    logic [7:0]  k;
    logic [63:0] m;

    assign k = i_sts.chain[r_abc][{r_col, 3'b000} +: 8];
    assign m = 64'hFF << {r_col, 3'b000};

    // table ports and engine requests
    always_comb begin
        o_cmd        = '0;
        o_cmd.seed   = 1'b1;
        o_cmd.passes = PASS_W'(MIN_PASSES);
        o_cmd.start  = (r_state == G_STEP) && (r_abc == 2'd2);
        o_rd_own     = (r_state == G_RD);
        for (int t = 0; t < 4; t++) begin
            o_rd.addr[t][0] = r_i;
            o_rd.addr[t][1] = k;
        end
        o_wr = '0;
        unique case (r_state)
            G_FILL: begin
                o_wr.en   = 4'hF;
                o_wr.addr = r_i;
                o_wr.data = {8{r_i}};
            end
            G_W1: begin
                o_wr.en[r_sb] = 1'b1;
                o_wr.addr     = r_i;
                o_wr.data     = (r_di & ~m) | (r_dk & m);
            end
            G_W2: begin
                o_wr.en[r_sb] = 1'b1;
                o_wr.addr     = r_k;
                o_wr.data     = (r_dk & ~m) | (r_di & m);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_FILL;
            r_i     <= '0;
            r_cnt   <= '0;
            r_sb    <= '0;
            r_abc   <= 2'd2;
            r_col   <= '0;
        end else begin
            unique case (r_state)
                G_FILL: begin
                    r_i <= r_i + 8'd1;
                    if (r_i == 8'hFF) begin
                        r_state <= G_STEP;
                    end
                end
                G_STEP: begin
                    r_col <= '0;
                    if (r_abc == 2'd2) begin
                        r_abc   <= '0;
                        r_state <= G_WAIT;
                    end else begin
                        r_abc   <= r_abc + 2'd1;
                        r_state <= G_RD;
                    end
                end
                G_WAIT: begin
                    if (i_sts.done) begin
                        r_state <= G_RD;
                    end
                end
                G_RD: begin
                    r_k     <= k;
                    r_state <= G_CAP;
                end
                G_CAP: begin
                    r_di    <= i_rdata[r_sb][0];
                    r_dk    <= i_rdata[r_sb][1];
                    r_state <= G_W1;
                end
                G_W1: r_state <= G_W2;
                G_W2: begin
                    r_col <= r_col + 3'd1;
                    if (r_col != 3'd7) begin
                        r_state <= G_RD;
                    end else begin
                        r_sb    <= r_sb + 2'd1;
                        r_state <= G_STEP;
                        if (r_sb == 2'd3) begin
                            r_i <= r_i + 8'd1;
                            if (r_i == 8'hFF) begin
                                r_cnt <= r_cnt + 3'd1;
                                if (r_cnt == 3'd4) begin
                                    r_state <= G_DONE;
                                end
                            end
                        end
                    end
                end
                G_DONE: ;
                default: r_state <= G_DONE;
            endcase
        end
    end

    assign o_done = (r_state == G_DONE);

endmodule

// File: rtl/core/tiger_hash_192.sv
// Top level of the Tiger-192 hash engine: message framing, padding, APB register, digest output.
`timescale 1ns / 1ps

// Tiger-192 over a byte message given as little-endian 64-bit words. After
// reset the engine builds its S-boxes in place (a fill of the 256 table
// rows, then 5120 permutation steps and 1707 three-pass seed compressions);
// no word is taken until that is done. The eighth word of a block starts a
// compression of P passes in the single shared round unit, and no word is
// taken while it runs: each round reads the S-boxes, adds and multiplies,
// and the key schedule steps run between passes. A final word adds its
// padding words, one or two compressions and a load of the digest, which
// is then held in an output register, so the next message may begin while
// it waits to be taken. num_passes (APB address 0) applies from the next
// compression; values below 3 or above 8 count as 3 or 8.
module tiger_hash_192 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tgr_in_if.sink                      i_in,
    tgr_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tgr_pkg::APB_AW-1:0]  paddr,
    input  logic [tgr_pkg::APB_DW-1:0]  pwdata,
    output logic [tgr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tgr_pkg::*;

    localparam logic [2:0] T_INIT = 3'd0;
    localparam logic [2:0] T_IDLE = 3'd1;
    localparam logic [2:0] T_PAD  = 3'd2;
    localparam logic [2:0] T_COMP = 3'd3;
    localparam logic [2:0] T_FIN  = 3'd4;

    logic [2:0]      r_state, n_state, r_ret, n_ret;
    logic [2:0]      r_idx, n_idx;
    logic [63:0]     r_bits, n_bits;
    logic            r_pend, n_pend;
    logic [VB_W-1:0] r_np;
    logic            r_out_valid;
    logic [63:0]     r_dig_a, r_dig_b, r_dig_c;

    t_cmp_cmd    gen_cmd, cmd;
    t_cmp_sts    sts;
    t_sbox_rd    gen_rd, cmp_rd, sbox_rd;
    t_sbox_wr    gen_wr;
    t_sbox_rdata rdata;
    logic        gen_rd_own, gen_done;

    logic            in_acc, push, load_out;
    logic [63:0]     pword, padword, pmask;
    logic [2:0]      pret;
    logic [VB_W-1:0] vbc;

    tgr_sbox u_sbox (
        .i_clk   (i_clk),
        .i_rd    (sbox_rd),
        .i_wr    (gen_wr),
        .o_rdata (rdata)
    );

    tgr_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_rdata (rdata),
        .o_rd    (cmp_rd),
        .o_sts   (sts)
    );

    tgr_sgen u_sgen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sts    (sts),
        .i_rdata  (rdata),
        .o_cmd    (gen_cmd),
        .o_rd     (gen_rd),
        .o_rd_own (gen_rd_own),
        .o_wr     (gen_wr),
        .o_done   (gen_done)
    );

    assign sbox_rd = gen_rd_own ? gen_rd : cmp_rd;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_PASSES) ? APB_DW'(r_np) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np <= NUM_PASSES_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NUM_PASSES)) begin
            r_np <= pwdata[VB_W-1:0];
        end
    end

    // final word padding
    assign vbc     = (i_in.valid_bytes > 4'd8) ? 4'd8 : i_in.valid_bytes;
    assign pmask   = (64'd1 << {vbc[2:0], 3'b000}) - 64'd1;
    assign padword = (i_in.data_word & pmask) | (64'd1 << {vbc[2:0], 3'b000});

    assign i_in.ready = (r_state == T_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // message sequencer
    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_ret    = r_ret;
        n_idx    = r_idx;
        n_bits   = r_bits;
        n_pend   = r_pend;
        load_out = 1'b0;
        push     = 1'b0;
        pword    = '0;
        pret     = T_IDLE;
        unique case (r_state)
            T_INIT: begin
                cmd = gen_cmd;
                if (gen_done) begin
                    cmd.init = 1'b1;
                    n_state  = T_IDLE;
                end
            end
            T_IDLE: begin
                if (in_acc) begin
                    push = 1'b1;
                    if (!i_in.last_word) begin
                        pword  = i_in.data_word;
                        n_bits = r_bits + 64'd64;
                    end else begin
                        pret   = T_PAD;
                        n_bits = r_bits + 64'({vbc, 3'b000});
                        if (vbc == 4'd8) begin
                            pword  = i_in.data_word;
                            n_pend = 1'b1;
                        end else begin
                            pword  = padword;
                            n_pend = 1'b0;
                        end
                    end
                end
            end
            T_PAD: begin
                push = 1'b1;
                pret = T_PAD;
                if (r_pend) begin
                    pword  = 64'd1;
                    n_pend = 1'b0;
                end else if (r_idx == 3'd7) begin
                    pword = r_bits;
                    pret  = T_FIN;
                end
            end
            T_COMP: begin
                if (sts.done) begin
                    n_state = r_ret;
                end
            end
            T_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    cmd.init = 1'b1;
                    n_idx    = '0;
                    n_bits   = '0;
                    n_state  = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase

        // one word into the block; the eighth starts a compression
        if (push) begin
            cmd.shift = 1'b1;
            cmd.word  = pword;
            if (r_idx == 3'd7) begin
                n_idx      = '0;
                cmd.start  = 1'b1;
                cmd.passes = eff_passes(r_np);
                n_ret      = pret;
                n_state    = T_COMP;
            end else begin
                n_idx   = r_idx + 3'd1;
                n_state = pret;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_INIT;
            r_ret   <= T_IDLE;
            r_idx   <= '0;
            r_bits  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
            r_bits  <= n_bits;
            r_pend  <= n_pend;
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_dig_a <= sts.chain[0];
            r_dig_b <= sts.chain[1];
            r_dig_c <= sts.chain[2];
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.digest_a = r_dig_a;
    assign o_out.digest_b = r_dig_b;
    assign o_out.digest_c = r_dig_c;

endmodule

// File: test/tb_tiger_hash_192.sv
// Self-checking testbench for the Tiger-192 hash engine with a built-in digest predictor.
`timescale 1ns / 1ps

module tb_tiger_hash_192;
    import tgr_pkg::*;

    typedef logic [2:0][63:0] chain_t;
    typedef logic [7:0][63:0] block_t;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } msg_word_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } digest_t;

    localparam int WATCHDOG_LIMIT = 2000000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLD_CYCLES    = 3000;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    tgr_in_if  in_ch ();
    tgr_out_if out_ch ();

    tiger_hash_192 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor state
    logic [63:0] sbox [1024];
    chain_t      msg_chain;
    block_t      msg_block;
    int          msg_widx;
    logic [63:0] msg_bits;
    logic [3:0]  cfg_passes;

    msg_word_t   word_q[$];
    digest_t     digest_q[$];

    int          errors;
    int          words_sent;
    int          digests_seen;
    int          idle_cycles;
    bit          steady;
    bit          hold_req;
    bit          hold_used;
    int          hold_cnt;

    function automatic block_t mix_key_block(block_t xi);
        block_t x;
        x = xi;
        x[0] = x[0] - (x[7] ^ KS_FIRST);
        x[1] = x[1] ^ x[0];
        x[2] = x[2] + x[1];
        x[3] = x[3] - (x[2] ^ ((~x[1]) << 19));
        x[4] = x[4] ^ x[3];
        x[5] = x[5] + x[4];
        x[6] = x[6] - (x[5] ^ ((~x[4]) >> 23));
        x[7] = x[7] ^ x[6];
        x[0] = x[0] + x[7];
        x[1] = x[1] - (x[0] ^ ((~x[7]) << 19));
        x[2] = x[2] ^ x[1];
        x[3] = x[3] + x[2];
        x[4] = x[4] - (x[3] ^ ((~x[2]) >> 23));
        x[5] = x[5] ^ x[4];
        x[6] = x[6] + x[5];
        x[7] = x[7] - (x[6] ^ KS_LAST);
        return x;
    endfunction

    function automatic chain_t compress_chain(block_t blk, chain_t st, int passes);
        block_t      x;
        chain_t      s;
        chain_t      res;
        logic [63:0] mul;
        logic [63:0] v;
        logic [63:0] t;
        int          ia;
        int          ib;
        int          ic;
        x = blk;
        s = st;
        for (int p = 0; p < passes; p++) begin
            mul = (p == 0) ? 64'd5 : (p == 1) ? 64'd7 : 64'd9;
            if (p != 0) begin
                x = mix_key_block(x);
            end
            for (int r = 0; r < 8; r++) begin
                // the three chain words rotate roles every round
                case (r % 3)
                    0: begin ia = 0; ib = 1; ic = 2; end
                    1: begin ia = 1; ib = 2; ic = 0; end
                    default: begin ia = 2; ib = 0; ic = 1; end
                endcase
                v = s[ic] ^ x[r];
                s[ic] = v;
                s[ia] = s[ia] - (sbox[v[7:0]] ^ sbox[256 + v[23:16]]
                                 ^ sbox[512 + v[39:32]] ^ sbox[768 + v[55:48]]);
                s[ib] = (s[ib] + (sbox[768 + v[15:8]] ^ sbox[512 + v[31:24]]
                                  ^ sbox[256 + v[47:40]] ^ sbox[v[63:56]])) * mul;
            end
            t = s[0]; s[0] = s[2]; s[2] = s[1]; s[1] = t;
        end
        res[0] = st[0] ^ s[0];
        res[1] = s[1] - st[1];
        res[2] = st[2] + s[2];
        return res;
    endfunction

    // S-box generation from the seed block, as the engine does after reset
    task automatic build_sboxes();
        chain_t st;
        int     abc;
        int     k;
        int     sh;
        logic [7:0] tmp;
        st[0] = IV_A; st[1] = IV_B; st[2] = IV_C;
        for (int i = 0; i < 1024; i++) begin
            sbox[i] = 64'(i & 255) * 64'h0101010101010101;
        end
        abc = 2;
        for (int cnt = 0; cnt < 5; cnt++) begin
            for (int i = 0; i < 256; i++) begin
                for (int sb = 0; sb < 1024; sb += 256) begin
                    abc++;
                    if (abc == 3) begin
                        abc = 0;
                        st = compress_chain(SEED_BLOCK, st, 3);
                    end
                    for (int col = 0; col < 8; col++) begin
                        sh = 8 * col;
                        k = int'(st[abc][sh +: 8]);
                        tmp = sbox[sb + i][sh +: 8];
                        sbox[sb + i][sh +: 8] = sbox[sb + k][sh +: 8];
                        sbox[sb + k][sh +: 8] = tmp;
                    end
                end
            end
        end
    endtask

    task automatic start_message();
        msg_chain[0] = IV_A; msg_chain[1] = IV_B; msg_chain[2] = IV_C;
        msg_block = '0;
        msg_widx = 0;
        msg_bits = '0;
    endtask

    task automatic absorb_word(logic [63:0] w);
        int passes;
        msg_block[msg_widx] = w;
        msg_widx++;
        if (msg_widx == 8) begin
            passes = (cfg_passes < 3) ? 3 : (cfg_passes > 8) ? 8 : int'(cfg_passes);
            msg_chain = compress_chain(msg_block, msg_chain, passes);
            msg_widx = 0;
        end
    endtask

    // Expected digest bookkeeping for one accepted word
    task automatic predict_word(msg_word_t w);
        int          nb;
        logic [63:0] mask;
        logic [63:0] pad;
        digest_t     d;
        if (!w.last_word) begin
            absorb_word(w.data_word);
            msg_bits = msg_bits + 64'd64;
        end else begin
            nb = (w.valid_bytes > 8) ? 8 : int'(w.valid_bytes);
            msg_bits = msg_bits + 64'(8 * nb);
            if (nb == 8) begin
                absorb_word(w.data_word);
                pad = 64'd1;
            end else begin
                mask = (nb == 0) ? 64'd0 : ((64'd1 << (8 * nb)) - 64'd1);
                pad = (w.data_word & mask) | (64'd1 << (8 * nb));
            end
            absorb_word(pad);
            while (msg_widx != 7) begin
                absorb_word(64'd0);
            end
            absorb_word(msg_bits);
            d.a = msg_chain[0];
            d.b = msg_chain[1];
            d.c = msg_chain[2];
            digest_q.push_back(d);
            start_message();
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (word_q.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
                msg_word_t w;
                w = word_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.data_word   <= w.data_word;
                in_ch.valid_bytes <= w.valid_bytes;
                in_ch.last_word   <= w.last_word;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Digest sink with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // Monitors: predict on each input transfer, check each digest transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_word('{in_ch.data_word, in_ch.valid_bytes, in_ch.last_word});
                words_sent <= words_sent + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                digests_seen <= digests_seen + 1;
                if (digest_q.size() == 0) begin
                    report_mismatch("digest with none expected", out_ch.digest_a, 64'd0);
                end else begin
                    digest_t d;
                    d = digest_q.pop_front();
                    if (out_ch.digest_a !== d.a) report_mismatch("digest_a", out_ch.digest_a, d.a);
                    if (out_ch.digest_b !== d.b) report_mismatch("digest_b", out_ch.digest_b, d.b);
                    if (out_ch.digest_c !== d.c) report_mismatch("digest_c", out_ch.digest_c, d.c);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout with %0d digests outstanding", digest_q.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register index 0 is the pass count; other indexes are ignored
        if (addr[2] == REG_NUM_PASSES) begin
            cfg_passes = value[3:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (word_q.size() != 0 || in_ch.valid || digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_word(logic [63:0] d, logic [3:0] vb, logic last);
        word_q.push_back('{d, vb, last});
    endtask

    // One message of random content; occasionally long
    task automatic queue_message();
        int len;
        logic [3:0] vb;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(10);
        for (int i = 0; i < len; i++) begin
            queue_word(rand64(), 4'($urandom_range(15)), 1'b0);
        end
        vb = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        queue_word(rand64(), vb, 1'b1);
    endtask

    localparam int NUM_PHASES = 9;
    int phase_passes [NUM_PHASES] = '{8, 0, 15, 5, 4, 9, 1, 7, 3};

    initial begin
        int target;
        errors = 0; words_sent = 0; digests_seen = 0; idle_cycles = 0;
        steady = 1'b0; hold_req = 1'b0; hold_used = 1'b0; hold_cnt = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.data_word = '0; in_ch.valid_bytes = '0;
        in_ch.last_word = 1'b0; out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        cfg_passes = NUM_PASSES_RST;
        build_sboxes();
        start_message();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default pass count, and a write to an unused register
        apb_write(3'd0, 32'd3);
        apb_write(3'd4, 32'd8);
        queue_word('1, 4'd0, 1'b1);                 // padding only
        queue_word('1, 4'd8, 1'b1);                 // full final word, padding in the next word
        queue_word('0, 4'd8, 1'b1);
        for (int vb = 1; vb < 8; vb++) begin
            queue_word(rand64(), 4'(vb), 1'b1);
        end
        queue_word('1, 4'd9, 1'b1);                 // byte count clamps to eight
        queue_word('1, 4'd15, 1'b1);
        for (int i = 0; i < 7; i++) begin           // pad lands in the last slot
            queue_word((i % 2) ? '1 : '0, 4'($urandom_range(15)), 1'b0);
        end
        queue_word('1, 4'd3, 1'b1);
        for (int i = 0; i < 3; i++) begin
            queue_word('1, 4'd0, 1'b0);
        end
        queue_word('0, 4'd8, 1'b1);
        wait_drained();

        // Random phases over a range of pass counts
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apb_write(3'd0, 32'(phase_passes[ph]));
            steady = (ph == 2);
            if (ph == 4) hold_req = 1'b1;
            target = words_sent + 32;
            while (words_sent + word_q.size() < target) queue_message();
            // sender pauses until every digest is in
            wait_drained();
            target = words_sent + 32;
            while (words_sent + word_q.size() < target) queue_message();
            wait_drained();
        end

        $display("Sent %0d message words and checked %0d digests", words_sent, digests_seen);
        $display("Pass counts below, inside and above the supported range, with stalls and a long sink hold-off");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
